// ===== rtl/bfa_pkg.sv =====
package bfa_pkg;

    localparam int REG_W     = 15;
    localparam int CFG_IDX_W = 2;

    // request kinds
    localparam logic [2:0] KIND_INIT       = 3'd0;
    localparam logic [2:0] KIND_ALLOC      = 3'd1;
    localparam logic [2:0] KIND_FREE_ADDR  = 3'd2;
    localparam logic [2:0] KIND_MARK_USED  = 3'd3;
    localparam logic [2:0] KIND_MARK_FREE  = 3'd4;
    localparam logic [2:0] KIND_QUERY      = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_START   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_END = 2'd2;

    localparam logic [REG_W-1:0] FRAME_COUNT_RST  = 15'd16384;
    localparam logic [REG_W-1:0] FREE_START_RST   = 15'd256;
    localparam logic [REG_W-1:0] RESERVED_END_RST = 15'd256;
    localparam logic [REG_W-1:0] CNT_RST          = 15'd16384;

    typedef struct packed {
        logic [2:0]  kind;
        logic [13:0] frame_index;
        logic [31:0] phys_address;
    } t_req;

    typedef struct packed {
        logic [31:0] alloc_address;
        logic        ok;
        logic        is_free_bit;
        logic [14:0] used_count;
    } t_rsp;

endpackage

// ===== rtl/bfa_map.sv =====
module bfa_map #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/bfa_locate.sv =====
// Turns a request's frame (by index or by address) into map word and bit.
// Divisions by the constant frame size and word size are reciprocal multiplies.
module bfa_locate #(
    parameter int MAX_FRAMES    = 16384,
    parameter int FRAME_BYTES   = 4096,
    parameter int MAP_WORD_BITS = 64,
    localparam int FW        = $clog2(MAX_FRAMES),
    localparam int LW        = $clog2(MAP_WORD_BITS),
    localparam int CW        = (FW + 1 > 15) ? FW + 1 : 15,
    localparam int MAP_WORDS = (MAX_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS,
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic                                 i_use_addr,
    input  logic [13:0]                          i_frame_index,
    input  logic [31:0]                          i_phys_address,
    input  logic [CW-1:0]                        i_n,
    output logic                                 o_valid,
    output logic                                 o_in_range,
    output logic [AW-1:0]                        o_word,
    output logic [LW-1:0]                        o_bit
);

    localparam int L_FB      = $clog2(FRAME_BYTES);
    localparam int QAW       = 33 - L_FB;
    localparam int CMPW      = (QAW > CW) ? QAW : CW;

    localparam logic [33:0] ADDR_M = 34'(((66'd1 << (32 + L_FB)) + 66'(FRAME_BYTES) - 66'd1)
                                         / 66'(FRAME_BYTES));
    localparam logic [FW:0] WORD_M = (FW + 1)'(((64'd1 << (FW + LW))
                                         + 64'(MAP_WORD_BITS) - 64'd1) / 64'(MAP_WORD_BITS));

    logic          r_v0, r_v1, r_v2, r_v3;
    logic [49:0]   r_plo, r_phi;
    logic [13:0]   r_idx;
    logic          r_use_addr;
    logic          r_inr1, r_inr2, r_inr3;
    logic [FW-1:0] r_f1, r_f2;
    logic [AW-1:0] r_word2, r_word3;
    logic [LW-1:0] r_bit3;

    logic [65:0]     addr_sum;
    logic [QAW-1:0]  addr_frame;
    logic [CMPW-1:0] frame_sel;
    logic [2*FW:0]   word_prod;
    logic [FW:0]     rem;

    always_comb begin
        addr_sum   = {r_phi, 16'd0} + {16'd0, r_plo};
        addr_frame = addr_sum[32 + L_FB +: QAW];
        frame_sel  = r_use_addr ? CMPW'(addr_frame) : CMPW'(r_idx);
        word_prod  = (2 * FW + 1)'(r_f1) * (2 * FW + 1)'(WORD_M);
        rem        = {1'b0, r_f2} - (FW + 1)'(r_word2) * (FW + 1)'(MAP_WORD_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v0 <= i_start;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_plo      <= i_phys_address[15:0] * ADDR_M;
            r_phi      <= i_phys_address[31:16] * ADDR_M;
            r_idx      <= i_frame_index;
            r_use_addr <= i_use_addr;
        end
        if (r_v0) begin
            r_inr1 <= frame_sel < CMPW'(i_n);
            r_f1   <= frame_sel[FW-1:0];
        end
        if (r_v1) begin
            r_inr2  <= r_inr1;
            r_f2    <= r_f1;
            r_word2 <= word_prod[FW + LW +: AW];
        end
        if (r_v2) begin
            r_inr3  <= r_inr2;
            r_word3 <= r_word2;
            r_bit3  <= rem[LW-1:0];
        end
    end

    assign o_valid    = r_v3;
    assign o_in_range = r_inr3;
    assign o_word     = r_word3;
    assign o_bit      = r_bit3;

endmodule

// ===== rtl/bitmap_frame_allocator_top.sv =====
// Bitmap frame allocator: one used bit per frame, kept in a word-wide map RAM.
// Request channel (i_req_valid/o_req_ready, payload t_req) takes one command at
// a time; each command returns exactly one response on o_rsp_valid/i_rsp_ready.
// Flow from acceptance to response valid:
//   mark used/free, free by address, query: 4 locate stages, then 1 RAM read
//     of the frame's map word, which is written back if it changes.
//   alloc: map words are read from word 0 up to the first free bit; the scan
//     streams one RAM word per cycle. A scan that finds nothing answers
//     with ok low once it has checked the last word.
//   init: every map word is rewritten, one per cycle.
//   kinds 6 and 7: ok low, nothing changes.
// After reset all MAP_WORDS map words (256 by default) are swept to all used,
// during which o_req_ready stays low; config writes are taken as usual.
// The response sits in an output register; a new request is accepted while it
// waits. If the receiver stalls, a finished result is parked in a hold
// register and no further request is taken until it moves out.
// Config writes (i_cfg_we) must only happen while no command is in flight.
module bitmap_frame_allocator_top #(
    parameter int MAX_FRAMES    = 16384,
    parameter int FRAME_BYTES   = 4096,
    parameter int MAP_WORD_BITS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  bfa_pkg::t_req                 i_req,
    output logic                          o_rsp_valid,
    input  logic                          i_rsp_ready,
    output bfa_pkg::t_rsp                 o_rsp,
    input  logic                          i_cfg_we,
    input  logic [bfa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bfa_pkg::REG_W-1:0]     i_cfg_wdata
);

    localparam int FW        = $clog2(MAX_FRAMES);
    localparam int LW        = $clog2(MAP_WORD_BITS);
    localparam int L_FB      = $clog2(FRAME_BYTES);
    localparam int CW        = (FW + 1 > 15) ? FW + 1 : 15;
    localparam int MAP_WORDS = (MAX_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int AMW       = (FW + L_FB + 1 > 32) ? FW + L_FB + 1 : 32;
    localparam int CNT_W     = CW;
    localparam int REG_W     = bfa_pkg::REG_W;
    localparam logic [AW-1:0] LAST_W = AW'(MAP_WORDS - 1);

    typedef enum logic [7:0] {
        S_CLEAR     = 8'b0000_0001,
        S_IDLE      = 8'b0000_0010,
        S_LOCATE    = 8'b0000_0100,
        S_MODIFY    = 8'b0000_1000,
        S_INIT      = 8'b0001_0000,
        S_SCAN      = 8'b0010_0000,
        S_ALLOC_OUT = 8'b0100_0000,
        S_HOLD      = 8'b1000_0000
    } t_state;

    // configuration
    logic [REG_W-1:0] r_frame_count, r_free_start, r_reserved_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count  <= bfa_pkg::FRAME_COUNT_RST;
            r_free_start   <= bfa_pkg::FREE_START_RST;
            r_reserved_end <= bfa_pkg::RESERVED_END_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bfa_pkg::CFG_FRAME_COUNT:  r_frame_count  <= i_cfg_wdata;
                bfa_pkg::CFG_FREE_START:   r_free_start   <= i_cfg_wdata;
                bfa_pkg::CFG_RESERVED_END: r_reserved_end <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [CW-1:0]    n_frames;
    logic [REG_W-1:0] lo;
    logic [CNT_W-1:0] init_cnt;

    always_comb begin
        n_frames = (CW'(r_frame_count) > CW'(MAX_FRAMES)) ? CW'(MAX_FRAMES)
                                                          : CW'(r_frame_count);
        lo       = (r_free_start > r_reserved_end) ? r_free_start : r_reserved_end;
        init_cnt = (n_frames > CW'(lo)) ? CNT_W'(lo) : CNT_W'(n_frames);
    end

    // state
    t_state           r_state, n_state;
    logic [2:0]       r_kind, n_kind;
    logic [AW-1:0]    r_w, n_w;
    logic [AW-1:0]    r_chk_w, n_chk_w;
    logic [CW-1:0]    r_base, n_base;
    logic             r_issue, n_issue;
    logic             r_pend, n_pend;
    logic [FW-1:0]    r_afr, n_afr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    bfa_pkg::t_rsp    r_rsp, n_rsp;
    logic             r_rsp_valid, n_rsp_valid;
    bfa_pkg::t_rsp    r_hold, n_hold;

    // map RAM
    logic                     rd_en, wr_en;
    logic [AW-1:0]            rd_addr, wr_addr;
    logic [MAP_WORD_BITS-1:0] rd_data, wr_data;

    bfa_map #(
        .WIDTH (MAP_WORD_BITS),
        .DEPTH (MAP_WORDS),
        .AW    (AW)
    ) u_map (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // frame locate pipeline
    logic          accept;
    logic          loc_start;
    logic          loc_valid, loc_inr;
    logic [AW-1:0] loc_word;
    logic [LW-1:0] loc_bit;

    assign o_req_ready = (r_state == S_IDLE);
    assign accept      = i_req_valid && o_req_ready;
    // only single-frame kinds enter the pipeline, so no stale result is left behind
    assign loc_start   = accept && ((i_req.kind == bfa_pkg::KIND_FREE_ADDR) ||
                                    (i_req.kind == bfa_pkg::KIND_MARK_USED) ||
                                    (i_req.kind == bfa_pkg::KIND_MARK_FREE) ||
                                    (i_req.kind == bfa_pkg::KIND_QUERY));

    bfa_locate #(
        .MAX_FRAMES    (MAX_FRAMES),
        .FRAME_BYTES   (FRAME_BYTES),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_locate (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (loc_start),
        .i_use_addr     (i_req.kind == bfa_pkg::KIND_FREE_ADDR),
        .i_frame_index  (i_req.frame_index),
        .i_phys_address (i_req.phys_address),
        .i_n            (n_frames),
        .o_valid        (loc_valid),
        .o_in_range     (loc_inr),
        .o_word         (loc_word),
        .o_bit          (loc_bit)
    );

    // per-word helpers
    logic [MAP_WORD_BITS-1:0] init_word;
    logic [LW-1:0]            zero_bit;
    logic [CW-1:0]            scan_frame;
    logic                     scan_stop;
    logic [AMW-1:0]           alloc_prod;
    logic                     cur_used;
    logic [MAP_WORD_BITS-1:0] loc_mask;

    always_comb begin
        for (int b = 0; b < MAP_WORD_BITS; b++) begin
            init_word[b] = !((r_base + CW'(b) >= CW'(lo)) && (r_base + CW'(b) < n_frames));
        end
        zero_bit = '0;
        for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
            if (!rd_data[i]) begin
                zero_bit = LW'(i);
            end
        end
        scan_frame = r_base + CW'(zero_bit);
        scan_stop  = (r_base + CW'(MAP_WORD_BITS) >= n_frames) || (r_chk_w == LAST_W);
        alloc_prod = AMW'(r_afr) * AMW'(FRAME_BYTES);
        cur_used   = rd_data[loc_bit];
        loc_mask   = MAP_WORD_BITS'(1) << loc_bit;
    end

    logic          out_free;
    logic          fin;
    bfa_pkg::t_rsp res;

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_w         = r_w;
        n_chk_w     = r_chk_w;
        n_base      = r_base;
        n_issue     = r_issue;
        n_pend      = r_pend;
        n_afr       = r_afr;
        n_cnt       = r_cnt;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid;
        n_hold      = r_hold;
        rd_en       = 1'b0;
        rd_addr     = r_w;
        wr_en       = 1'b0;
        wr_addr     = r_w;
        wr_data     = '1;
        fin         = 1'b0;
        res         = '0;
        out_free    = !r_rsp_valid || i_rsp_ready;

        if (r_rsp_valid && i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                wr_en  = 1'b1;
                n_w    = r_w + AW'(1);
                if (r_w == LAST_W) begin
                    n_w     = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_kind  = i_req.kind;
                    n_w     = '0;
                    n_chk_w = '0;
                    n_base  = '0;
                    n_issue = 1'b1;
                    n_pend  = 1'b0;
                    case (i_req.kind)
                        bfa_pkg::KIND_INIT:      n_state = S_INIT;
                        bfa_pkg::KIND_ALLOC:     n_state = S_SCAN;
                        bfa_pkg::KIND_FREE_ADDR,
                        bfa_pkg::KIND_MARK_USED,
                        bfa_pkg::KIND_MARK_FREE,
                        bfa_pkg::KIND_QUERY:     n_state = S_LOCATE;
                        default: begin
                            n_hold            = '0;
                            n_hold.used_count = r_cnt[REG_W-1:0];
                            n_state           = S_HOLD;
                        end
                    endcase
                end
            end
            S_LOCATE: begin
                if (loc_valid) begin
                    rd_en   = loc_inr;
                    rd_addr = loc_word;
                    n_state = S_MODIFY;
                end
            end
            S_MODIFY: begin
                fin     = 1'b1;
                wr_addr = loc_word;
                if (loc_inr) begin
                    res.ok = 1'b1;
                    case (r_kind)
                        bfa_pkg::KIND_QUERY: begin
                            res.is_free_bit = !cur_used;
                        end
                        bfa_pkg::KIND_MARK_USED: begin
                            if (!cur_used) begin
                                wr_en   = 1'b1;
                                wr_data = rd_data | loc_mask;
                                n_cnt   = r_cnt + CNT_W'(1);
                            end
                        end
                        default: begin
                            // free by address, mark free
                            if (cur_used) begin
                                wr_en   = 1'b1;
                                wr_data = rd_data & ~loc_mask;
                                if (r_cnt != '0) begin
                                    n_cnt = r_cnt - CNT_W'(1);
                                end
                            end
                        end
                    endcase
                end
            end
            S_INIT: begin
                wr_en   = 1'b1;
                wr_data = init_word;
                n_w     = r_w + AW'(1);
                n_base  = r_base + CW'(MAP_WORD_BITS);
                if (r_w == LAST_W) begin
                    n_cnt  = init_cnt;
                    res.ok = 1'b1;
                    fin    = 1'b1;
                end
            end
            S_SCAN: begin
                // reads run one word ahead of the check
                n_pend = r_issue;
                if (r_issue) begin
                    rd_en = 1'b1;
                    if (r_w == LAST_W) begin
                        n_issue = 1'b0;
                    end else begin
                        n_w = r_w + AW'(1);
                    end
                end
                if (r_pend) begin
                    if (rd_data != '1) begin
                        if (scan_frame < n_frames) begin
                            wr_en   = 1'b1;
                            wr_addr = r_chk_w;
                            wr_data = rd_data | (MAP_WORD_BITS'(1) << zero_bit);
                            n_cnt   = r_cnt + CNT_W'(1);
                            n_afr   = scan_frame[FW-1:0];
                            n_state = S_ALLOC_OUT;
                        end else begin
                            fin = 1'b1;
                        end
                    end else if (scan_stop) begin
                        fin = 1'b1;
                    end else begin
                        n_chk_w = r_chk_w + AW'(1);
                        n_base  = r_base + CW'(MAP_WORD_BITS);
                    end
                end
            end
            S_ALLOC_OUT: begin
                res.alloc_address = alloc_prod[31:0];
                res.ok            = 1'b1;
                fin               = 1'b1;
            end
            S_HOLD: begin
                if (out_free) begin
                    n_rsp       = r_hold;
                    n_rsp_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        res.used_count = n_cnt[REG_W-1:0];

        if (fin) begin
            if (out_free) begin
                n_rsp       = res;
                n_rsp_valid = 1'b1;
                n_state     = S_IDLE;
            end else begin
                n_hold  = res;
                n_state = S_HOLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_w         <= '0;
            r_chk_w     <= '0;
            r_base      <= '0;
            r_issue     <= 1'b0;
            r_pend      <= 1'b0;
            r_cnt       <= CNT_W'(bfa_pkg::CNT_RST);
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_w         <= n_w;
            r_chk_w     <= n_chk_w;
            r_base      <= n_base;
            r_issue     <= n_issue;
            r_pend      <= n_pend;
            r_cnt       <= n_cnt;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_afr  <= n_afr;
        r_rsp  <= n_rsp;
        r_hold <= n_hold;
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule
